/* sv/i2a_pkg.sv */
// ----------------------------------------------------------------------------
// i2a_pkg: shared constants and helpers for integer_to_ascii_digits
// Sizes of the value, digit register and counters, plus the digit-to-ASCII map.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // number width taken part in conversion
  localparam int VALUE_BITS = 32;
  // width of the value field on the input port
  localparam int IN_BITS = 32;

  // decimal digits needed: floor(VALUE_BITS * log10(2)) + 1
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  // hexadecimal digits needed
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  // digit register holds either form (decimal count is never smaller)
  localparam int DIG_W = DEC_DIGITS * 4;

  localparam int CNT_W  = $clog2(DEC_DIGITS + 1);
  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_A    = 8'h61;

  // radix select codes
  localparam logic KIND_DEC = 1'b0;
  localparam logic KIND_HEX = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  // map a 4-bit digit to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = ASCII_ZERO + {4'd0, d};
    end else begin
      ch = ASCII_A + {4'd0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

/* sv/integer_to_ascii_digits.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: unsigned binary to ASCII decimal or hex digits
// Converts one number per request and streams its digits out, most
// significant first, no leading zeros, with a flag on the final digit.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid/in_ready with in_kind (0 decimal, 1 lower-case
//   hex) and in_value. in_ready is high only while the block is idle.
//   Output channel: out_valid/out_ready with out_character (ASCII digit) and
//   out_last, set on the least significant digit. A zero value gives a
//   single '0' with out_last set.
//   Timing: decimal requests run one shift-add-3 step per cycle through a
//   shared BCD adjust unit, one step for each bit of the value. Leading
//   zero digits are then shifted out one by one in the skip pass (at most 9
//   for decimal, 9 for hex since the digit register is 10 digits wide),
//   and the first digit is loaded into the output register. Hex requests
//   skip the conversion pass. Digits go out back to back while the
//   receiver is ready. The next request is taken the cycle after the last
//   digit is accepted.
//   Stalls: the output register holds the current digit until out_ready;
//   the sequencer waits with it.
//   Reset: rst_n (synchronous, active low) returns to idle and drops
//   out_valid; no state is kept between requests.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [i2a_pkg::IN_BITS-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_character,
  output logic                          out_last
);

  i2a_pkg::state_t                    state_r, state_nxt;
  logic [i2a_pkg::VALUE_BITS-1:0]     bin_r, bin_nxt;
  logic [i2a_pkg::DIG_W-1:0]          digits_r, digits_nxt;
  logic [i2a_pkg::DIG_W-1:0]          digits_adj;
  logic [i2a_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [i2a_pkg::STEP_W-1:0]         step_r, step_nxt;
  logic [7:0]                         char_r, char_nxt;
  logic                               last_r, last_nxt;
  logic [3:0]                         top_digit;
  logic [3:0]                         second_digit;
  logic                               in_acc;
  logic                               out_acc;

  assign in_ready      = (state_r == i2a_pkg::ST_IDLE);
  assign out_valid     = (state_r == i2a_pkg::ST_SEND);
  assign out_character = char_r;
  assign out_last      = last_r;
  assign in_acc        = in_valid && in_ready;
  assign out_acc       = out_valid && out_ready;

  assign top_digit    = digits_r[i2a_pkg::DIG_W-1 -: 4];
  assign second_digit = digits_r[i2a_pkg::DIG_W-5 -: 4];

  // shared bcd adjust unit: add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
      if (digits_r[i*4 +: 4] >= 4'd5) begin
        digits_adj[i*4 +: 4] = digits_r[i*4 +: 4] + 4'd3;
      end else begin
        digits_adj[i*4 +: 4] = digits_r[i*4 +: 4];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    bin_nxt    = bin_r;
    digits_nxt = digits_r;
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    char_nxt   = char_r;
    last_nxt   = last_r;
    case (state_r)
      i2a_pkg::ST_IDLE: begin
        if (in_acc) begin
          bin_nxt  = i2a_pkg::VALUE_BITS'(in_value);
          cnt_nxt  = i2a_pkg::CNT_W'(i2a_pkg::DEC_DIGITS);
          step_nxt = i2a_pkg::STEP_W'(i2a_pkg::VALUE_BITS);
          if (in_kind == i2a_pkg::KIND_HEX) begin
            digits_nxt = i2a_pkg::DIG_W'(i2a_pkg::VALUE_BITS'(in_value));
            state_nxt  = i2a_pkg::ST_SKIP;
          end else begin
            digits_nxt = '0;
            state_nxt  = i2a_pkg::ST_CONV;
          end
        end
      end
      i2a_pkg::ST_CONV: begin
        // one double-dabble step per cycle
        digits_nxt = {digits_adj[i2a_pkg::DIG_W-2:0], bin_r[i2a_pkg::VALUE_BITS-1]};
        bin_nxt    = {bin_r[i2a_pkg::VALUE_BITS-2:0], 1'b0};
        step_nxt   = step_r - i2a_pkg::STEP_W'(1);
        if (step_r == i2a_pkg::STEP_W'(1)) begin
          state_nxt = i2a_pkg::ST_SKIP;
        end
      end
      i2a_pkg::ST_SKIP: begin
        // drop leading zeros, always keep the final digit
        if (top_digit == 4'd0 && cnt_r != i2a_pkg::CNT_W'(1)) begin
          digits_nxt = {digits_r[i2a_pkg::DIG_W-5:0], 4'd0};
          cnt_nxt    = cnt_r - i2a_pkg::CNT_W'(1);
        end else begin
          char_nxt  = i2a_pkg::digit_char(top_digit);
          last_nxt  = (cnt_r == i2a_pkg::CNT_W'(1));
          state_nxt = i2a_pkg::ST_SEND;
        end
      end
      i2a_pkg::ST_SEND: begin
        if (out_acc) begin
          if (last_r) begin
            state_nxt = i2a_pkg::ST_IDLE;
          end else begin
            digits_nxt = {digits_r[i2a_pkg::DIG_W-5:0], 4'd0};
            cnt_nxt    = cnt_r - i2a_pkg::CNT_W'(1);
            char_nxt   = i2a_pkg::digit_char(second_digit);
            last_nxt   = (cnt_r == i2a_pkg::CNT_W'(2));
          end
        end
      end
      default: begin
        state_nxt = i2a_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2a_pkg::ST_IDLE;
      cnt_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    bin_r    <= bin_nxt;
    digits_r <= digits_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a digit is pending");

  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (cnt_r == i2a_pkg::CNT_W'(1))))
    else $error("last flag does not match remaining digit count");

  a_send_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != '0))
    else $error("digit sent with empty count");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> in_ready)
    else $error("not idle after final digit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready right after accepting a request");

endmodule

/* verif/integer_to_ascii_digits_tb.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_tb: self-checking bench for the digit converter
// Feeds decimal and hex conversion requests through a gapped driver and
// checks every emitted character and last flag against an internal
// most-significant-first digit predictor, with random output back-pressure.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_tb;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 3;
  localparam int RANDOM_REQS  = 410;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic                         kind;
    logic [i2a_pkg::IN_BITS-1:0]  value;
    int unsigned                  gap;
  } conv_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } digit_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_kind = 1'b0;
  logic [i2a_pkg::IN_BITS-1:0] in_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [7:0]                  out_character;
  logic                        out_last;

  conv_req_t   pending_reqs[$];
  digit_t      expected_digits[$];
  int unsigned mismatch_count = 0;
  bit          quiet_in = 1'b0;

  integer_to_ascii_digits u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

  always #CLK_HALF clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return 0;
    end else if (r < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // expected characters of one request, most significant digit first
  task automatic predict_digits(input logic kind,
                                input logic [i2a_pkg::IN_BITS-1:0] value);
    logic [7:0]  rev_chars [24];
    logic [63:0] n;
    logic [63:0] radix;
    logic [63:0] d;
    int          count;
    digit_t      dig;
    n     = 64'(value) & ((~64'd0) >> (64 - i2a_pkg::VALUE_BITS));
    radix = (kind == i2a_pkg::KIND_HEX) ? 64'd16 : 64'd10;
    count = 0;
    do begin
      d = n % radix;
      if (d < 64'd10) begin
        rev_chars[count] = i2a_pkg::ASCII_ZERO + d[7:0];
      end else begin
        rev_chars[count] = i2a_pkg::ASCII_A + d[7:0] - 8'd10;
      end
      count++;
      n = n / radix;
    end while (n != 64'd0);
    for (int k = 0; k < count; k++) begin
      dig.ch   = rev_chars[count - 1 - k];
      dig.last = (k == count - 1);
      expected_digits.push_back(dig);
    end
  endtask

  task automatic queue_req(input logic kind, input logic [i2a_pkg::IN_BITS-1:0] value);
    conv_req_t req;
    req.kind  = kind;
    req.value = value;
    req.gap   = quiet_in ? 0 : draw_gap();
    pending_reqs.push_back(req);
  endtask

  // request driver: waits out the gap, then holds valid until accepted
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    conv_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_digits(in_kind, in_value);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_kind  <= req.kind;
          in_value <= req.value;
          gap_left = req.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // digit monitor with random back-pressure in bursts
  int unsigned hold_cycles = 0;
  int unsigned burst_left = 0;
  bit          quiet_out = 1'b0;
  always @(posedge clk) begin
    digit_t exp_dig;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected digit, expected none, got char 8'h%02h last %0b",
                   $time, out_character, out_last);
          mismatch_count++;
        end else begin
          exp_dig = expected_digits.pop_front();
          if (out_character !== exp_dig.ch) begin
            $display("%0t: character mismatch, expected 8'h%02h, got 8'h%02h",
                     $time, exp_dig.ch, out_character);
            mismatch_count++;
          end
          if (out_last !== exp_dig.last) begin
            $display("%0t: last flag mismatch, expected %0b, got %0b",
                     $time, exp_dig.last, out_last);
            mismatch_count++;
          end
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(20, 100);
          quiet_out  = ($urandom_range(0, 3) == 0);
        end else begin
          burst_left--;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
        hold_cycles = draw_gap();
        out_ready <= (hold_cycles == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [i2a_pkg::IN_BITS-1:0] val;
    longint unsigned             pw;
    int unsigned                 sel;
    int unsigned                 nbits;
    int unsigned                 exp10;

    // directed: zero, single digits, radix boundaries, widest values, hex letters
    queue_req(i2a_pkg::KIND_DEC, 32'd0);
    queue_req(i2a_pkg::KIND_HEX, 32'd0);
    queue_req(i2a_pkg::KIND_DEC, 32'd1);
    queue_req(i2a_pkg::KIND_HEX, 32'd1);
    queue_req(i2a_pkg::KIND_DEC, 32'd9);
    queue_req(i2a_pkg::KIND_DEC, 32'd10);
    queue_req(i2a_pkg::KIND_DEC, 32'd100);
    queue_req(i2a_pkg::KIND_HEX, 32'ha);
    queue_req(i2a_pkg::KIND_HEX, 32'hf);
    queue_req(i2a_pkg::KIND_HEX, 32'h10);
    queue_req(i2a_pkg::KIND_DEC, 32'd4294967295);
    queue_req(i2a_pkg::KIND_HEX, 32'hffff_ffff);
    queue_req(i2a_pkg::KIND_DEC, 32'd1000000000);
    queue_req(i2a_pkg::KIND_DEC, 32'd999999999);
    queue_req(i2a_pkg::KIND_HEX, 32'h1000_0000);
    queue_req(i2a_pkg::KIND_HEX, 32'h0fff_ffff);
    queue_req(i2a_pkg::KIND_HEX, 32'hdead_beef);
    queue_req(i2a_pkg::KIND_HEX, 32'h0123_abcd);
    queue_req(i2a_pkg::KIND_HEX, 32'hfedc_ba98);
    queue_req(i2a_pkg::KIND_DEC, 32'h8000_0000);
    queue_req(i2a_pkg::KIND_HEX, 32'h8000_0000);
    queue_req(i2a_pkg::KIND_DEC, 32'd12345678);

    // random: mixed magnitudes, powers of the radix and neighbors, zeros
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 40 == 0) begin
        quiet_in = ($urandom_range(0, 2) == 0);
      end
      sel = $urandom_range(0, 19);
      if (sel < 6) begin
        val = $urandom;
      end else if (sel < 15) begin
        nbits = $urandom_range(1, i2a_pkg::IN_BITS);
        val   = $urandom & ((i2a_pkg::IN_BITS)'((64'd1 << nbits) - 64'd1));
      end else if (sel < 18) begin
        exp10 = $urandom_range(1, 9);
        pw    = 1;
        for (int k = 0; k < exp10; k++) begin
          pw = pw * 10;
        end
        val = (i2a_pkg::IN_BITS)'(pw - longint'($urandom_range(0, 1)));
      end else if (sel < 19) begin
        nbits = $urandom_range(1, 7) * 4;
        val   = (i2a_pkg::IN_BITS)'((64'd1 << nbits) - 64'($urandom_range(0, 1)));
      end else begin
        val = '0;
      end
      queue_req(logic'($urandom_range(0, 1)), val);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // sample at the falling edge so driver updates have settled
    while (pending_reqs.size() != 0 || in_valid || expected_digits.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/i2a_pkg.sv
sv/integer_to_ascii_digits.sv
verif/integer_to_ascii_digits_tb.sv
